### rtl/uam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uam_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int FUNC_W   = 2;
    localparam int NAME_W   = 8;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 8;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FN_LOAD   = 2'd0;
    localparam t_func FN_ADD    = 2'd1;
    localparam t_func FN_REMOVE = 2'd2;
    localparam t_func FN_QUERY  = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_PRESENT   = 2'd2;
    localparam t_status ST_ABSENT    = 2'd3;

endpackage

`default_nettype wire

### rtl/uam_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface uam_in_if
    import uam_pkg::*;
();
    logic              valid;
    logic              ready;
    t_func             func;
    logic [NAME_W-1:0] name_a;
    logic [NAME_W-1:0] name_b;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, func, name_a, name_b, slot_index, input ready);
    modport sink   (input valid, func, name_a, name_b, slot_index, output ready);
endinterface

`default_nettype wire

### rtl/uam_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface uam_out_if
    import uam_pkg::*;
();
    logic              valid;
    logic              ready;
    t_status           status;
    logic              edge_present;
    logic [SLOT_W-1:0] index_first;
    logic [SLOT_W-1:0] index_second;

    modport source (output valid, status, edge_present, index_first, index_second,
                    input ready);
    modport sink   (input valid, status, edge_present, index_first, index_second,
                    output ready);
endinterface

`default_nettype wire

### rtl/uam_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module uam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

### rtl/undirected_adjacency_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

// Undirected graph store: a table of vertex name bytes and a symmetric edge bit matrix, both
// in block RAM with a registered read. A load item writes its name into the name table and
// posts its result. An edge item first looks up both names by one pass over the first
// min(vertex_count, MAX_VERTICES) slots, one slot per cycle through the single read port of
// the name RAM, stopping early once both are found. The matrix row of the first vertex is then
// read and modified; a query or a refused change ends there, while an add or remove writes
// that row and then reads and writes the row of the second vertex. A last step posts the
// result to the output register. The input is not ready while an item is in work; a result
// that waits in the output register does not block the next accept.
// The edge matrix reads as all zero after reset through per-row valid bits, so no clearing pass
// is needed.
module undirected_adjacency_matrix
    import uam_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    uam_in_if.sink                i_in,
    uam_out_if.source             o_out
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_RD_A   = 3'd2;
    localparam logic [2:0] S_MOD_A  = 3'd3;
    localparam logic [2:0] S_RD_B   = 3'd4;
    localparam logic [2:0] S_MOD_B  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [CFG_W-1:0]        r_vcount, n_vcount;
    logic [MAX_VERTICES-1:0] r_loaded, n_loaded;
    logic [MAX_VERTICES-1:0] r_row_vld, n_row_vld;
    logic                    r_out_vld, n_out_vld;
    logic                    r_pend, n_pend;
    logic                    r_fa, n_fa;
    logic                    r_fb, n_fb;

    t_func                   r_func, n_func;
    logic [NAME_W-1:0]       r_name_a, n_name_a;
    logic [NAME_W-1:0]       r_name_b, n_name_b;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [ADDR_W-1:0]       r_pend_idx, n_pend_idx;
    logic                    r_pend_ld, n_pend_ld;
    logic [ADDR_W-1:0]       r_ia, n_ia;
    logic [ADDR_W-1:0]       r_ib, n_ib;
    t_status                 r_st, n_st;
    logic                    r_pres, n_pres;
    t_status                 r_o_status, n_o_status;
    logic                    r_o_pres, n_o_pres;
    logic [SLOT_W-1:0]       r_o_ia, n_o_ia;
    logic [SLOT_W-1:0]       r_o_ib, n_o_ib;

    logic [CNT_W-1:0]        w_limit;
    logic                    w_slot_ok;
    logic                    w_nm_we;
    logic [NAME_W-1:0]       w_nm_rdata;
    logic                    w_eg_we;
    logic [ADDR_W-1:0]       w_eg_raddr;
    logic [ADDR_W-1:0]       w_row;
    logic [ADDR_W-1:0]       w_bit;
    logic [MAX_VERTICES-1:0] w_eg_rdata;
    logic [MAX_VERTICES-1:0] w_base;
    logic [MAX_VERTICES-1:0] w_mask;
    logic [MAX_VERTICES-1:0] w_eg_wdata;
    logic                    w_edge;

    assign w_limit   = (int'(r_vcount) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                       : CNT_W'(r_vcount);
    assign w_slot_ok = int'(i_in.slot_index) < MAX_VERTICES;

    assign w_eg_raddr = (r_state == S_RD_B) ? r_ib : r_ia;
    assign w_row      = (r_state == S_MOD_B) ? r_ib : r_ia;
    assign w_bit      = (r_state == S_MOD_B) ? r_ia : r_ib;
    assign w_base     = r_row_vld[w_row] ? w_eg_rdata : '0;
    assign w_mask     = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << w_bit;
    assign w_eg_wdata = (r_func == FN_ADD) ? (w_base | w_mask) : (w_base & ~w_mask);
    assign w_edge     = w_base[w_bit];

    uam_ram #(
        .WIDTH (NAME_W),
        .DEPTH (MAX_VERTICES)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_nm_we),
        .i_waddr (ADDR_W'(i_in.slot_index)),
        .i_wdata (i_in.name_a),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_nm_rdata)
    );

    uam_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_eg_we),
        .i_waddr (w_row),
        .i_wdata (w_eg_wdata),
        .i_raddr (w_eg_raddr),
        .o_rdata (w_eg_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_vcount   = i_cfg_we ? i_cfg_wdata : r_vcount;
        n_loaded   = r_loaded;
        n_row_vld  = r_row_vld;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_pend     = 1'b0;
        n_fa       = r_fa;
        n_fb       = r_fb;
        n_func     = r_func;
        n_name_a   = r_name_a;
        n_name_b   = r_name_b;
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_pend_idx = r_pend_idx;
        n_pend_ld  = r_pend_ld;
        n_ia       = r_ia;
        n_ib       = r_ib;
        n_st       = r_st;
        n_pres     = r_pres;
        n_o_status = r_o_status;
        n_o_pres   = r_o_pres;
        n_o_ia     = r_o_ia;
        n_o_ib     = r_o_ib;
        w_nm_we    = 1'b0;
        w_eg_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func   = i_in.func;
                    n_name_a = i_in.name_a;
                    n_name_b = i_in.name_b;
                    n_slot   = i_in.slot_index;
                    n_ia     = '0;
                    n_ib     = '0;
                    n_pres   = 1'b0;
                    if (i_in.func == FN_LOAD) begin
                        if (w_slot_ok) begin
                            w_nm_we = 1'b1;
                            n_loaded[ADDR_W'(i_in.slot_index)] = 1'b1;
                            n_st = ST_OK;
                        end else begin
                            n_st = ST_NOT_FOUND;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_fa    = 1'b0;
                        n_fb    = 1'b0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_pend && r_pend_ld && !r_fa && (w_nm_rdata == r_name_a)) begin
                    n_fa = 1'b1;
                    n_ia = r_pend_idx;
                end
                if (r_pend && r_pend_ld && !r_fb && (w_nm_rdata == r_name_b)) begin
                    n_fb = 1'b1;
                    n_ib = r_pend_idx;
                end
                if (r_fa && r_fb) begin
                    n_state = S_RD_A;
                end else if ((r_idx >= w_limit) && !r_pend) begin
                    n_st    = ST_NOT_FOUND;
                    n_pres  = 1'b0;
                    n_state = S_DONE;
                end else if (r_idx < w_limit) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[ADDR_W-1:0];
                    n_pend_ld  = r_loaded[r_idx[ADDR_W-1:0]];
                    n_idx      = r_idx + CNT_W'(1);
                end
            end
            S_RD_A: begin
                n_state = S_MOD_A;
            end
            S_MOD_A: begin
                case (r_func)
                    FN_ADD: begin
                        n_pres = 1'b1;
                        if (w_edge) begin
                            n_st    = ST_PRESENT;
                            n_state = S_DONE;
                        end else begin
                            w_eg_we          = 1'b1;
                            n_row_vld[r_ia]  = 1'b1;
                            n_st             = ST_OK;
                            n_state          = S_RD_B;
                        end
                    end
                    FN_REMOVE: begin
                        n_pres = 1'b0;
                        if (!w_edge) begin
                            n_st    = ST_ABSENT;
                            n_state = S_DONE;
                        end else begin
                            w_eg_we          = 1'b1;
                            n_row_vld[r_ia]  = 1'b1;
                            n_st             = ST_OK;
                            n_state          = S_RD_B;
                        end
                    end
                    default: begin
                        n_st    = w_edge ? ST_OK : ST_ABSENT;
                        n_pres  = w_edge;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_B: begin
                n_state = S_MOD_B;
            end
            S_MOD_B: begin
                w_eg_we         = 1'b1;
                n_row_vld[r_ib] = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_o_status = r_st;
                    n_o_pres   = r_pres;
                    n_o_ia     = (r_func == FN_LOAD) ? r_slot : SLOT_W'(r_ia);
                    n_o_ib     = SLOT_W'(r_ib);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= '0;
            r_loaded  <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_fa      <= 1'b0;
            r_fb      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vcount  <= n_vcount;
            r_loaded  <= n_loaded;
            r_row_vld <= n_row_vld;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
            r_fa      <= n_fa;
            r_fb      <= n_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_name_a   <= n_name_a;
        r_name_b   <= n_name_b;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_ld  <= n_pend_ld;
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_st       <= n_st;
        r_pres     <= n_pres;
        r_o_status <= n_o_status;
        r_o_pres   <= n_o_pres;
        r_o_ia     <= n_o_ia;
        r_o_ib     <= n_o_ib;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.status       = r_o_status;
    assign o_out.edge_present = r_o_pres;
    assign o_out.index_first  = r_o_ia;
    assign o_out.index_second = r_o_ib;

    a_edge_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eg_we |-> ((r_state == S_MOD_A) || (r_state == S_MOD_B)))
        else $error("Edge matrix written outside the update steps.");

    a_row_read_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_A) |-> (r_fa && r_fb))
        else $error("Matrix access started without both vertices found.");

    a_found_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && r_fa) |-> (CNT_W'(r_ia) < w_limit))
        else $error("First vertex found beyond the searched slots.");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_vld && !o_out.ready) |=> (r_state == S_DONE))
        else $error("Result overwrote an item still waiting at the output.");

    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_eg_we && (r_func == FN_REMOVE)) |-> !w_eg_wdata[w_bit])
        else $error("Remove left the edge bit set.");

endmodule

`default_nettype wire

### sim/tb_undirected_adjacency_matrix.sv
`timescale 1ns / 1ps

module tb_undirected_adjacency_matrix;
    import uam_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 150;
    localparam int POOL_SIZE   = 24;
    localparam logic [NAME_W-1:0] NAME_FAR  = 8'h77;
    localparam logic [NAME_W-1:0] NAME_NONE = 8'h5A;

    typedef struct packed {
        t_func             func;
        logic [NAME_W-1:0] name_a;
        logic [NAME_W-1:0] name_b;
        logic [SLOT_W-1:0] slot;
    } t_graph_op;

    typedef struct packed {
        t_status           status;
        logic              present;
        logic [SLOT_W-1:0] idx_a;
        logic [SLOT_W-1:0] idx_b;
    } t_graph_resp;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    uam_in_if  in_if ();
    uam_out_if out_if ();

    undirected_adjacency_matrix uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [NAME_W-1:0]     vertex_name [MAX_VERTICES];
    bit                    vertex_loaded [MAX_VERTICES];
    bit [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
    int unsigned           vertex_count;
    logic [NAME_W-1:0]     name_pool [POOL_SIZE];

    t_graph_resp expected_resp [$];
    int          err_count;
    int          item_count;
    int          resp_count;
    int          setting_count;
    int          quiet_cycles;
    bit          gaps_on;
    bit          hold_request;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic int unsigned search_limit();
        return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
    endfunction

    function automatic bit find_vertex(input logic [NAME_W-1:0] nm,
                                       output logic [SLOT_W-1:0] idx);
        int unsigned limit;
        limit = search_limit();
        idx = '0;
        for (int unsigned i = 0; i < limit; i++) begin
            if (vertex_loaded[i] && vertex_name[i] == nm) begin
                idx = SLOT_W'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_graph_resp apply_graph_op(input t_graph_op op);
        t_graph_resp r;
        bit          found_a;
        bit          found_b;
        bit          linked;
        r = '0;
        r.status = ST_OK;
        if (op.func == FN_LOAD) begin
            vertex_name[op.slot]   = op.name_a;
            vertex_loaded[op.slot] = 1'b1;
            r.idx_a = op.slot;
            return r;
        end
        found_a = find_vertex(op.name_a, r.idx_a);
        found_b = find_vertex(op.name_b, r.idx_b);
        if (!found_a || !found_b) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        linked = adjacency[r.idx_a][r.idx_b];
        case (op.func)
            FN_ADD: begin
                if (linked) begin
                    r.status = ST_PRESENT;
                end else begin
                    adjacency[r.idx_a][r.idx_b] = 1'b1;
                    adjacency[r.idx_b][r.idx_a] = 1'b1;
                end
                r.present = 1'b1;
            end
            FN_REMOVE: begin
                if (!linked) begin
                    r.status = ST_ABSENT;
                end else begin
                    adjacency[r.idx_a][r.idx_b] = 1'b0;
                    adjacency[r.idx_b][r.idx_a] = 1'b0;
                end
                r.present = 1'b0;
            end
            default: begin
                r.status  = linked ? ST_OK : ST_ABSENT;
                r.present = linked;
            end
        endcase
        return r;
    endfunction

    function automatic t_graph_op graph_op(input t_func f, input logic [NAME_W-1:0] a,
                                           input logic [NAME_W-1:0] b,
                                           input logic [SLOT_W-1:0] s);
        t_graph_op op;
        op.func   = f;
        op.name_a = a;
        op.name_b = b;
        op.slot   = s;
        return op;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        int unsigned limit;
        limit = search_limit();
        if (limit != 0 && $urandom_range(99) < 85) begin
            return vertex_name[$urandom_range(limit - 1)];
        end
        return NAME_W'($urandom);
    endfunction

    // Edge items mostly name vertices that are searched, so that edges build up.
    function automatic t_graph_op random_op();
        t_graph_op   op;
        int          r;
        int unsigned limit;
        limit = search_limit();
        r = $urandom_range(99);
        if (r < 10) begin
            op.func = FN_LOAD;
        end else if (r < 40) begin
            op.func = FN_ADD;
        end else if (r < 65) begin
            op.func = FN_REMOVE;
        end else begin
            op.func = FN_QUERY;
        end
        if (op.func == FN_LOAD) begin
            op.name_a = ($urandom_range(99) < 70) ? name_pool[$urandom_range(POOL_SIZE - 1)]
                                                  : NAME_W'($urandom);
            op.name_b = NAME_W'($urandom);
        end else begin
            op.name_a = pick_name();
            op.name_b = pick_name();
        end
        if (limit != 0 && $urandom_range(1) == 0) begin
            op.slot = SLOT_W'($urandom_range(limit - 1));
        end else begin
            op.slot = SLOT_W'($urandom);
        end
        return op;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_item(input t_graph_op op);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        in_if.func       = op.func;
        in_if.name_a     = op.name_a;
        in_if.name_b     = op.name_b;
        in_if.slot_index = op.slot;
        in_if.valid      = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_resp.push_back(apply_graph_op(op));
        item_count++;
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        if (in_if.valid) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        while (expected_resp.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input int unsigned value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        vertex_count = value & 8'hFF;
        setting_count++;
    endtask

    always @(posedge i_clk) begin
        t_graph_resp want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            resp_count++;
            if (expected_resp.size() == 0) begin
                report_mismatch($sformatf("result with no item outstanding, status %0d",
                                          out_if.status));
            end else begin
                want = expected_resp.pop_front();
                if (out_if.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              out_if.status, want.status));
                if (out_if.edge_present !== want.present)
                    report_mismatch($sformatf("edge_present got %0d expected %0d",
                                              out_if.edge_present, want.present));
                if (out_if.index_first !== want.idx_a)
                    report_mismatch($sformatf("index_first got %0d expected %0d",
                                              out_if.index_first, want.idx_a));
                if (out_if.index_second !== want.idx_b)
                    report_mismatch($sformatf("index_second got %0d expected %0d",
                                              out_if.index_second, want.idx_b));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without an accepted item.", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                out_if.ready = 1'b1;
            end else if (stall > 0) begin
                out_if.ready = 1'b0;
                stall--;
            end else begin
                out_if.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic test_empty_graph();
        set_vertex_count(0);
        send_item(graph_op(FN_ADD, 8'h00, 8'hFF, '0));
        send_item(graph_op(FN_QUERY, 8'h12, 8'h34, '1));
        send_item(graph_op(FN_REMOVE, 8'hFF, 8'hFF, '0));
        send_item(graph_op(FN_LOAD, 8'hFF, 8'h00, '1));
        wait_drained();
    endtask

    // Every slot is loaded before any search can reach it.
    task automatic test_fill_table();
        logic [NAME_W-1:0] v;
        name_pool[0] = 8'h00;
        name_pool[1] = 8'hFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            v = NAME_W'($urandom);
            while (v == NAME_FAR) v = NAME_W'($urandom);
            name_pool[i] = v;
        end
        for (int s = 0; s < MAX_VERTICES; s++) begin
            send_item(graph_op(FN_LOAD, name_pool[$urandom_range(POOL_SIZE - 1)],
                               NAME_W'($urandom), SLOT_W'(s)));
        end
        wait_drained();
    endtask

    task automatic test_directed_edges();
        set_vertex_count(4);
        send_item(graph_op(FN_LOAD, 8'h00, 8'h00, 7'd0));
        send_item(graph_op(FN_LOAD, 8'hFF, 8'h00, 7'd1));
        send_item(graph_op(FN_LOAD, 8'hA5, 8'h00, 7'd2));
        send_item(graph_op(FN_LOAD, 8'h00, 8'h00, 7'd3));
        send_item(graph_op(FN_ADD, 8'h00, 8'hFF, '0));
        send_item(graph_op(FN_ADD, 8'hFF, 8'h00, '0));
        send_item(graph_op(FN_QUERY, 8'hFF, 8'h00, '0));
        send_item(graph_op(FN_REMOVE, 8'h00, 8'hFF, '0));
        send_item(graph_op(FN_REMOVE, 8'hFF, 8'h00, '0));
        send_item(graph_op(FN_QUERY, 8'h00, 8'hFF, '0));
        send_item(graph_op(FN_ADD, 8'hA5, 8'hA5, '0));
        send_item(graph_op(FN_QUERY, 8'hA5, 8'hA5, '0));
        send_item(graph_op(FN_QUERY, 8'hFF, NAME_NONE, '0));
        send_item(graph_op(FN_ADD, NAME_NONE, 8'hA5, '0));
        set_vertex_count(255);
        send_item(graph_op(FN_LOAD, NAME_FAR, 8'h00, 7'd127));
        send_item(graph_op(FN_QUERY, NAME_FAR, 8'h00, '0));
        send_item(graph_op(FN_ADD, NAME_FAR, 8'hFF, '0));
        set_vertex_count(128);
        send_item(graph_op(FN_QUERY, 8'hFF, NAME_FAR, '0));
        set_vertex_count(127);
        send_item(graph_op(FN_REMOVE, NAME_FAR, 8'hFF, '0));
        set_vertex_count(1);
        send_item(graph_op(FN_ADD, 8'h00, 8'h00, '0));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int n,
                                       input bit with_gaps);
        set_vertex_count(count);
        gaps_on = with_gaps;
        repeat (n) send_item(random_op());
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // The output is held off while items keep coming, so the block must stall its input.
    task automatic test_output_hold();
        set_vertex_count(8);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (12) send_item(random_op());
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        set_vertex_count(16);
        repeat (20) begin
            send_item(random_op());
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.func       = FN_LOAD;
        in_if.name_a     = '0;
        in_if.name_b     = '0;
        in_if.slot_index = '0;
        out_if.ready     = 1'b0;
        vertex_count     = 0;
        err_count        = 0;
        item_count       = 0;
        resp_count       = 0;
        setting_count    = 0;
        quiet_cycles     = 0;
        gaps_on          = 1'b1;
        hold_request     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_graph();
        test_fill_table();
        test_directed_edges();
        test_random_traffic(2, 100, 1'b1);
        test_random_traffic(8, 160, 1'b1);
        test_output_hold();
        test_random_traffic(30, 250, 1'b0);
        test_random_traffic(1, 50, 1'b1);
        test_drain_pause();
        test_random_traffic(128, 80, 1'b1);
        test_random_traffic(255, 60, 1'b0);
        test_random_traffic(64, 150, 1'b1);
        repeat (3) test_random_traffic($urandom_range(255), 60, 1'b1);
        test_random_traffic(0, 40, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results over %0d vertex-count settings,",
                 item_count, resp_count, setting_count);
        $display("with unknown names, counts past capacity, an output hold-off and drains.");
        if (err_count == 0 && expected_resp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
